FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion wrappers shared by the rtl, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/mlb_pkg.sv
// ----------------------------------------------------------------------------
// mlb_pkg
// types and constants of the learning bridge forwarder
// ----------------------------------------------------------------------------
package mlb_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NUM_PORTS   = 8;

    localparam int MAC_W     = 48;
    localparam int IN_PORT_W = 4;
    localparam int ENT_PORT_W = 3;
    localparam int MASK_W    = 8;
    localparam int PERIOD_W  = 20;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd30000;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ACT_FORWARD = 2'd0,
        ACT_FLOOD   = 2'd1,
        ACT_DROP    = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

FILE: rtl/core/mlb_ram.sv
// ----------------------------------------------------------------------------
// mlb_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/core/mac_learning_bridge_forwarder.sv
// ----------------------------------------------------------------------------
// mac_learning_bridge_forwarder
// forwarding decision and source learning for a transparent ethernet bridge
// ----------------------------------------------------------------------------
// usage
//   command channel: an item transfers at a clock edge with start high and
//   busy low. i_command selects a frame decision or one time tick.
//   result channel: o_done is high for exactly one cycle with the result on
//   o_action, o_egress_mask, o_learned, o_table_full and o_flushed. the
//   receiver cannot stall, so each result must be taken in that cycle.
//   config: i_cfg_we writes i_cfg_wdata into the flush period, idle only.
// timing
//   tick or bad ingress port: result in the cycle after the transfer, busy
//   never rises, so a new item may follow at once.
//   frame: the learned table is scanned one entry per cycle through the
//   table ram read port, then the scan and finish states lead to the
//   result; busy covers that span and a new item is accepted in the cycle
//   the result is shown.
// reset
//   table empty (fill count zero), tick count zero, period 30000. the ram
//   itself is not cleared; only entries below the fill count are read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mac_learning_bridge_forwarder #(
    parameter int TABLE_DEPTH = mlb_pkg::TABLE_DEPTH,
    parameter int NUM_PORTS   = mlb_pkg::NUM_PORTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [mlb_pkg::IN_PORT_W-1:0] i_in_port,
    input  logic [mlb_pkg::MAC_W-1:0]     i_dest_mac,
    input  logic [mlb_pkg::MAC_W-1:0]     i_src_mac,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [mlb_pkg::PERIOD_W-1:0]  i_cfg_wdata,
    // result channel
    output logic                          o_done,
    output logic [1:0]                    o_action,
    output logic [mlb_pkg::MASK_W-1:0]    o_egress_mask,
    output logic                          o_learned,
    output logic                          o_table_full,
    output logic                          o_flushed
);

    localparam int AW      = $clog2(TABLE_DEPTH);
    localparam int CW      = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = mlb_pkg::MAC_W + mlb_pkg::ENT_PORT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [mlb_pkg::MASK_W-1:0] ALL_PORTS =
        mlb_pkg::MASK_W'((1 << NUM_PORTS) - 1);
    localparam logic [mlb_pkg::IN_PORT_W-1:0] MAX_PORT =
        mlb_pkg::IN_PORT_W'(NUM_PORTS);

    // control state
    mlb_pkg::t_state              r_state, n_state;
    logic [CW-1:0]                r_count;     // learned entries in the table
    logic [CW-1:0]                r_idx;       // next entry to read
    logic                         r_pend;      // read data valid this cycle
    logic [mlb_pkg::PERIOD_W-1:0] r_tick;
    logic [mlb_pkg::PERIOD_W-1:0] r_period;

    // scan results
    logic                             r_dfound;
    logic                             r_sfound;
    logic [mlb_pkg::ENT_PORT_W-1:0]   r_dport;

    // captured frame
    logic [mlb_pkg::IN_PORT_W-1:0] r_in_port;
    logic [mlb_pkg::MAC_W-1:0]     r_dest;
    logic [mlb_pkg::MAC_W-1:0]     r_src;

    // result register
    logic                        r_done;
    mlb_pkg::t_action            r_action;
    logic [mlb_pkg::MASK_W-1:0]  r_mask;
    logic                        r_learned;
    logic                        r_full;
    logic                        r_flushed;

    // ram interface
    logic               rd_en;
    logic               wr_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;

    logic accept;
    logic bad_port;
    logic [mlb_pkg::PERIOD_W-1:0] tick_next;
    logic [mlb_pkg::PERIOD_W-1:0] period_eff;
    logic flush_now;
    logic [mlb_pkg::IN_PORT_W-1:0] r_in_port_m1;
    logic src_new;
    logic has_room;
    logic dest_hit;
    logic src_hit;

    assign accept   = start && !busy;
    assign bad_port = (i_in_port == '0) || (i_in_port > MAX_PORT);
    assign r_in_port_m1 = r_in_port - 1'b1;

    // time base: a zero period behaves as one, so every tick flushes
    assign tick_next  = r_tick + 1'b1;
    assign period_eff = (r_period == '0) ? mlb_pkg::PERIOD_W'(1) : r_period;
    assign flush_now  = tick_next >= period_eff;

    // compare of the entry read in the previous cycle
    assign dest_hit = r_pend && (rd_data[mlb_pkg::MAC_W-1:0] == r_dest);
    assign src_hit  = r_pend && (rd_data[mlb_pkg::MAC_W-1:0] == r_src);

    // learning decision, valid once the scan is over
    assign src_new  = !r_sfound;
    assign has_room = r_count < DEPTH_C;
    assign wr_data  = {r_in_port_m1[mlb_pkg::ENT_PORT_W-1:0], r_src};

    mlb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mlb_pkg::ST_IDLE: begin
                if (accept && (i_command == mlb_pkg::CMD_FRAME) && !bad_port) begin
                    n_state = mlb_pkg::ST_SCAN;
                end
            end
            mlb_pkg::ST_SCAN: begin
                // last read data is compared on the same edge
                if (!rd_en) begin
                    n_state = mlb_pkg::ST_FINISH;
                end
            end
            mlb_pkg::ST_FINISH: begin
                n_state = mlb_pkg::ST_IDLE;
            end
            default: begin
                n_state = mlb_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        busy  = 1'b1;
        rd_en = 1'b0;
        wr_en = 1'b0;
        unique case (r_state)
            mlb_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            mlb_pkg::ST_SCAN: begin
                rd_en = r_idx < r_count;
            end
            mlb_pkg::ST_FINISH: begin
                wr_en = src_new && has_room;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mlb_pkg::ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_tick   <= '0;
            r_period <= mlb_pkg::PERIOD_RESET;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            // strobe after a tick, a bad port or the end of a frame scan
            r_done  <= (accept && ((i_command == mlb_pkg::CMD_TICK) || bad_port))
                       || (r_state == mlb_pkg::ST_FINISH);
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (accept) begin
                r_idx <= '0;
                if (i_command == mlb_pkg::CMD_TICK) begin
                    if (flush_now) begin
                        r_tick  <= '0;
                        r_count <= '0;
                    end else begin
                        r_tick <= tick_next;
                    end
                end
            end
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if ((r_state == mlb_pkg::ST_FINISH) && wr_en) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // frame capture and scan flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_port <= i_in_port;
            r_dest    <= i_dest_mac;
            r_src     <= i_src_mac;
            r_dfound  <= 1'b0;
            r_sfound  <= 1'b0;
        end
        // first destination match wins
        if (dest_hit && !r_dfound) begin
            r_dfound <= 1'b1;
            r_dport  <= rd_data[ENTRY_W-1:mlb_pkg::MAC_W];
        end
        if (src_hit) begin
            r_sfound <= 1'b1;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && (i_command == mlb_pkg::CMD_TICK)) begin
            r_action  <= mlb_pkg::ACT_TICK;
            r_mask    <= '0;
            r_learned <= 1'b0;
            r_full    <= 1'b0;
            r_flushed <= flush_now;
        end else if (accept && bad_port) begin
            r_action  <= mlb_pkg::ACT_DROP;
            r_mask    <= '0;
            r_learned <= 1'b0;
            r_full    <= 1'b0;
            r_flushed <= 1'b0;
        end else if (r_state == mlb_pkg::ST_FINISH) begin
            r_learned <= src_new && has_room;
            r_full    <= src_new && !has_room;
            r_flushed <= 1'b0;
            priority if (!r_dfound) begin
                // unknown destination: every port but the ingress one
                r_action <= mlb_pkg::ACT_FLOOD;
                r_mask   <= ALL_PORTS & ~(mlb_pkg::MASK_W'(1) << r_in_port_m1);
            end else if (r_dport == r_in_port_m1[mlb_pkg::ENT_PORT_W-1:0]) begin
                r_action <= mlb_pkg::ACT_DROP;
                r_mask   <= '0;
            end else begin
                r_action <= mlb_pkg::ACT_FORWARD;
                r_mask   <= mlb_pkg::MASK_W'(1) << r_dport;
            end
        end
    end

    assign o_done        = r_done;
    assign o_action      = r_action;
    assign o_egress_mask = r_mask;
    assign o_learned     = r_learned;
    assign o_table_full  = r_full;
    assign o_flushed     = r_flushed;

    `ASSERT_ALWAYS(a_count_bound, r_count <= DEPTH_C)
    `ASSERT_IMPLY(a_scan_idx, r_state == mlb_pkg::ST_SCAN, r_idx <= r_count)
    `ASSERT_NEXT(a_finish_done, r_state == mlb_pkg::ST_FINISH, r_done && !busy)
    `ASSERT_IMPLY(a_learn_grow, r_done && r_learned, r_count == CW'($past(r_count) + 1'b1))
    `ASSERT_IMPLY(a_write_new, wr_en, !r_sfound && (r_count < DEPTH_C))

endmodule
